@@ rtl/mrfa_pkg.sv @@
// Shared types for the request frame aligner: actions, status codes,
// and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none
package mrfa_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_ALIGN = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ALIGNED  = 3'd0,
      ST_SHORT    = 3'd1,
      ST_OLD      = 3'd2,
      ST_LIMIT    = 3'd3,
      ST_INTERNAL = 3'd4,
      ST_READ     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      RS_OFS   = 3'd0,
      RS_P1    = 3'd1,
      RS_P4    = 3'd2,
      RS_P5    = 3'd3,
      RS_INDEX = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      HA_NONE = 2'd0,
      HA_ONE  = 2'd1,
      HA_TWO  = 2'd2,
      HA_LEN  = 2'd3
   } head_add_type;

   typedef struct packed {
      logic         lat_req;
      logic         rd_req;
      rd_sel_type   rd_sel;
      logic         wr_push;
      logic         wr_cmp;
      logic         ofs_clr;
      logic         ofs_inc;
      logic         cmp_done;
      logic         step_clr;
      logic         step_inc;
      head_add_type head_add;
      logic         lat_fc;
      logic         lat_qh;
      logic         lat_len;
      logic         crc_init;
      logic         crc_upd;
      logic         lat_crc_lo;
      logic         lat_start;
      logic         rsp_load;
      status_type   rsp_status;
   } cmd_type;

   typedef struct packed {
      logic head_zero;
      logic step_limit;
      logic avail_ge1;
      logic avail_ge2;
      logic avail_ge6;
      logic avail_ge_len;
      logic addr_ok;
      logic fc_ok;
      logic cmp_end;
      logic crc_end;
      logic crc_ok;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/mrfa_datapath.sv @@
// Datapath of the frame aligner: byte buffer, head/end indices, CRC
// engine, length decode and result registers. Depends on mrfa_pkg.
`default_nettype none
module mrfa_datapath #(
   parameter int DEPTH = 512
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mrfa_pkg::cmd_type cmd,
   output mrfa_pkg::stat_type    stat,
   input  wire logic [7:0]       own_address,
   input  wire logic [7:0]       req_rx_byte,
   input  wire logic [8:0]       req_read_index,
   output logic [2:0]            rsp_status,
   output logic [8:0]            rsp_frame_start,
   output logic [8:0]            rsp_frame_length,
   output logic [7:0]            rsp_function_code,
   output logic [7:0]            rsp_read_data
);
   import mrfa_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + 9;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      end
      return r;
   endfunction

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_q_ff;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] head_ff, head_in, end_ff, end_in, ofs_ff, ofs_in, step_ff, step_in;
   logic [CW-1:0] avail;
   logic [7:0]    rx_ff, fc_ff, qh_ff, crc_lo_ff;
   logic          oob_ff;
   logic [8:0]    flen_ff, flen_in, start_ff;
   logic [15:0]   crc_ff, qty;
   logic [16:0]   qty7;
   logic [AW+9:0] idx_wide;

   assign avail    = end_ff - head_ff;
   assign idx_wide = (AW + 10)'(req_read_index);
   assign qty      = {qh_ff, rd_q_ff};
   assign qty7     = 17'(qty) + 17'd7;

   always_comb begin
      case (cmd.rd_sel)
         RS_OFS:   rd_addr = AW'(head_ff + ofs_ff);
         RS_P1:    rd_addr = AW'(head_ff + CW'(1));
         RS_P4:    rd_addr = AW'(head_ff + CW'(4));
         RS_P5:    rd_addr = AW'(head_ff + CW'(5));
         RS_INDEX: rd_addr = idx_wide[AW-1:0];
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      if (fc_ff == 8'd15) begin
         flen_in = 9'd9 + 9'(qty7[10:3]);
      end else if (fc_ff == 8'd16) begin
         flen_in = 9'd9 + 9'({qty[6:0], 1'b0});
      end else begin
         flen_in = 9'd8;
      end
   end

   always_comb begin
      head_in = head_ff;
      end_in  = end_ff;
      case (cmd.head_add)
         HA_ONE:  head_in = head_ff + CW'(1);
         HA_TWO:  head_in = head_ff + CW'(2);
         HA_LEN:  head_in = CW'(XW'(head_ff) + XW'(flen_ff));
         default: head_in = head_ff;
      endcase
      if (cmd.cmp_done) begin
         head_in = '0;
         end_in  = avail;
      end
      if (cmd.wr_push && (end_ff < CW'(DEPTH))) begin
         end_in = end_ff + CW'(1);
      end
      ofs_in = ofs_ff;
      if (cmd.ofs_clr) begin
         ofs_in = '0;
      end else if (cmd.ofs_inc) begin
         ofs_in = ofs_ff + CW'(1);
      end
      step_in = step_ff;
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         end_ff  <= '0;
      end else begin
         head_ff <= head_in;
         end_ff  <= end_in;
      end
      ofs_ff  <= ofs_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_req) begin
         rd_q_ff <= mem[rd_addr];
      end
      if (cmd.wr_push && (end_ff < CW'(DEPTH))) begin
         mem[AW'(end_ff)] <= rx_ff;
      end else if (cmd.wr_cmp) begin
         mem[AW'(ofs_ff)] <= rd_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_req) begin
         rx_ff  <= req_rx_byte;
         oob_ff <= idx_wide >= (AW + 10)'(DEPTH);
      end
      if (cmd.lat_fc) begin
         fc_ff <= rd_q_ff;
      end
      if (cmd.lat_qh) begin
         qh_ff <= rd_q_ff;
      end
      if (cmd.lat_len) begin
         flen_ff <= flen_in;
      end
      if (cmd.crc_init) begin
         crc_ff <= 16'hFFFF;
      end else if (cmd.crc_upd) begin
         crc_ff <= crc_byte(crc_ff, rd_q_ff);
      end
      if (cmd.lat_crc_lo) begin
         crc_lo_ff <= rd_q_ff;
      end
      if (cmd.lat_start) begin
         start_ff <= 9'(head_ff);
      end
      if (cmd.rsp_load) begin
         rsp_status <= cmd.rsp_status;
         if (cmd.rsp_status == ST_ALIGNED) begin
            rsp_frame_start   <= start_ff;
            rsp_frame_length  <= flen_ff;
            rsp_function_code <= fc_ff;
         end else begin
            rsp_frame_start   <= '0;
            rsp_frame_length  <= '0;
            rsp_function_code <= '0;
         end
         rsp_read_data <= ((cmd.rsp_status == ST_READ) && !oob_ff) ? rd_q_ff : 8'h00;
      end
   end

   always_comb begin
      stat.head_zero    = (head_ff == '0);
      stat.step_limit   = (step_ff == CW'(DEPTH));
      stat.avail_ge1    = (avail >= CW'(1));
      stat.avail_ge2    = (avail >= CW'(2));
      stat.avail_ge6    = (avail >= CW'(6));
      stat.avail_ge_len = (XW'(avail) >= XW'(flen_ff));
      stat.addr_ok      = (rd_q_ff == own_address) || (rd_q_ff == 8'h00);
      stat.fc_ok        = ((rd_q_ff >= 8'd1) && (rd_q_ff <= 8'd6)) ||
                          (rd_q_ff == 8'd15) || (rd_q_ff == 8'd16);
      stat.cmp_end      = (ofs_ff == avail);
      stat.crc_end      = (XW'(ofs_ff) == XW'(flen_ff - 9'd2));
      stat.crc_ok       = ({rd_q_ff, crc_lo_ff} == crc_ff);
   end

endmodule
`default_nettype wire

@@ rtl/mrfa_ctrl.sv @@
// Controller of the frame aligner: sequences push/compaction, the align
// walk and reads, and owns the response valid. Depends on mrfa_pkg.
`default_nettype none
module mrfa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_action,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mrfa_pkg::cmd_type      cmd,
   input  wire mrfa_pkg::stat_type stat
);
   import mrfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_CMP_RD, S_CMP_WR, S_STEP, S_ADDR, S_FC, S_QH, S_QL,
      S_LEN, S_CRC_RD, S_CRC_UP, S_CL_RD, S_CL, S_CH, S_RESULT
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in, slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RS_OFS;
      cmd.head_add = HA_NONE;
      cmd.rsp_status = status_ff;
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.lat_req = 1'b1;
               case (action_type'(req_action))
                  ACT_PUSH: state_in = S_PUSH;
                  ACT_ALIGN: begin
                     cmd.step_clr = 1'b1;
                     cmd.ofs_clr  = 1'b1;
                     if (stat.head_zero) begin
                        state_in = S_STEP;
                     end else begin
                        status_in = ST_OLD;
                        state_in  = S_RESULT;
                     end
                  end
                  ACT_READ: begin
                     cmd.rd_req = 1'b1;
                     cmd.rd_sel = RS_INDEX;
                     status_in  = ST_READ;
                     state_in   = S_RESULT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PUSH: begin
            if (stat.head_zero) begin
               cmd.wr_push = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.ofs_clr = 1'b1;
               state_in    = S_CMP_RD;
            end
         end
         S_CMP_RD: begin
            if (stat.cmp_end) begin
               cmd.cmp_done = 1'b1;
               state_in     = S_PUSH;
            end else begin
               cmd.rd_req = 1'b1;
               state_in   = S_CMP_WR;
            end
         end
         S_CMP_WR: begin
            cmd.wr_cmp  = 1'b1;
            cmd.ofs_inc = 1'b1;
            state_in    = S_CMP_RD;
         end
         S_STEP: begin
            cmd.step_inc = 1'b1;
            if (stat.step_limit) begin
               status_in = ST_LIMIT;
               state_in  = S_RESULT;
            end else if (!stat.avail_ge1) begin
               status_in = ST_SHORT;
               state_in  = S_RESULT;
            end else begin
               cmd.ofs_clr = 1'b1;
               cmd.rd_req  = 1'b1;
               state_in    = S_ADDR;
            end
         end
         S_ADDR: begin
            if (!stat.addr_ok) begin
               cmd.head_add = HA_ONE;
               state_in     = S_STEP;
            end else if (!stat.avail_ge2) begin
               status_in = ST_SHORT;
               state_in  = S_RESULT;
            end else begin
               cmd.rd_req = 1'b1;
               cmd.rd_sel = RS_P1;
               state_in   = S_FC;
            end
         end
         S_FC: begin
            if (!stat.fc_ok) begin
               cmd.head_add = HA_TWO;
               state_in     = S_STEP;
            end else if (!stat.avail_ge6) begin
               status_in = ST_SHORT;
               state_in  = S_RESULT;
            end else begin
               cmd.lat_fc = 1'b1;
               cmd.rd_req = 1'b1;
               cmd.rd_sel = RS_P4;
               state_in   = S_QH;
            end
         end
         S_QH: begin
            cmd.lat_qh = 1'b1;
            cmd.rd_req = 1'b1;
            cmd.rd_sel = RS_P5;
            state_in   = S_QL;
         end
         S_QL: begin
            cmd.lat_len = 1'b1;
            state_in    = S_LEN;
         end
         S_LEN: begin
            if (!stat.avail_ge_len) begin
               status_in = ST_SHORT;
               state_in  = S_RESULT;
            end else begin
               cmd.crc_init = 1'b1;
               cmd.ofs_clr  = 1'b1;
               state_in     = S_CRC_RD;
            end
         end
         S_CRC_RD: begin
            cmd.rd_req  = 1'b1;
            cmd.ofs_inc = 1'b1;
            state_in    = S_CRC_UP;
         end
         S_CRC_UP: begin
            cmd.crc_upd = 1'b1;
            state_in    = stat.crc_end ? S_CL_RD : S_CRC_RD;
         end
         S_CL_RD: begin
            cmd.rd_req  = 1'b1;
            cmd.ofs_inc = 1'b1;
            state_in    = S_CL;
         end
         S_CL: begin
            cmd.lat_crc_lo = 1'b1;
            cmd.rd_req     = 1'b1;
            state_in       = S_CH;
         end
         S_CH: begin
            cmd.head_add = HA_LEN;
            cmd.ofs_clr  = 1'b1;
            if (stat.crc_ok) begin
               cmd.lat_start = 1'b1;
               status_in     = ST_ALIGNED;
               state_in      = S_RESULT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/modbus_rtu_request_frame_aligner.sv @@
// Top level of the Modbus RTU request frame aligner: address register,
// controller and datapath. Depends on mrfa_pkg, mrfa_ctrl, mrfa_datapath.
//
//   channel  direction  payload
//   req_     in         action, rx_byte, read_index
//   rsp_     out        status, frame_start, frame_length, function_code, read_data
//   csr_     in         own_address
//
// Push: with head at zero the byte is appended directly; otherwise the buffer is
// compacted first, each byte moved being read then written (single port buffer).
// Read: a single buffer read. Align: walks from head, skipping one byte for a bad
// address, two for a bad function code and a frame of L bytes whose CRC fails.
// Synchronous reset empties the buffer indices at once. A pending response
// holds the next result, and the input with it, until it is taken.
`default_nettype none
module modbus_rtu_request_frame_aligner #(
   parameter int BUFFER_DEPTH = 512
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [8:0] req_read_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [8:0]      rsp_frame_start,
   output logic [8:0]      rsp_frame_length,
   output logic [7:0]      rsp_function_code,
   output logic [7:0]      rsp_read_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_own_address
);
   import mrfa_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] own_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= 8'd1;
      end else if (csr_valid) begin
         own_ff <= csr_own_address;
      end
   end

   mrfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mrfa_datapath #(
      .DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .own_address       (own_ff),
      .req_rx_byte       (req_rx_byte),
      .req_read_index    (req_read_index),
      .rsp_status        (rsp_status),
      .rsp_frame_start   (rsp_frame_start),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_function_code (rsp_function_code),
      .rsp_read_data     (rsp_read_data)
   );

   a_zero_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ALIGNED) |->
         (rsp_frame_length == 9'd0) && (rsp_function_code == 8'd0))
      else $error("frame fields set on a non-aligned transaction");

   a_min_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ALIGNED) |-> (rsp_frame_length >= 9'd8))
      else $error("aligned frame shorter than minimum");

   a_no_internal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ST_INTERNAL))
      else $error("internal end status produced");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_READ) |-> (rsp_read_data == 8'd0))
      else $error("read data set on a non-read transaction");

endmodule
`default_nettype wire
